/* rtl/sgm_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_pkg
// Shared constants, register indexes and controller/datapath interface types
// for the sobel gradient magnitude block.
// ----------------------------------------------------------------------------
package sgm_pkg;

    localparam int SGM_MAX_WIDTH  = 1024;
    localparam int SGM_MAX_HEIGHT = 4096;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int MAG_W      = 11;
    localparam int CFG_WID_W  = 11;
    localparam int CFG_HGT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 12;
    localparam int SUM_W      = 10;
    localparam int SQ_W       = 21;

    localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = CFG_WID_W'(512);
    localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = CFG_HGT_W'(512);

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

    // first trial bit of the root search, highest even power below 2^SQ_W
    localparam logic [SQ_W-1:0] ROOT_BIT_INIT = SQ_W'(1) << (SQ_W - 1);

    typedef struct packed {
        logic clear_step;
        logic capture;
        logic update;
        logic square;
        logic root_step;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic clear_done;
        logic produce;
        logic root_done;
    } t_dp_status;

endpackage

/* rtl/sgm_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_ram
// Generic single-port RAM, one write or read address per cycle, registered
// read data.
// ----------------------------------------------------------------------------
module sgm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/sgm_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_ctrl
// Controller: line buffer clearing after reset, pixel intake, gradient and
// square root sequencing, and the result handshake.
// ----------------------------------------------------------------------------
module sgm_ctrl
    import sgm_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_pixel_valid,
    output logic       o_pixel_ready,
    output logic       o_result_valid,
    input  logic       i_result_ready,
    output t_dp_cmd    o_cmd,
    input  t_dp_status i_status
);

    typedef enum logic [6:0] {
        S_CLEAR  = 7'b0000001,
        S_IDLE   = 7'b0000010,
        S_UPDATE = 7'b0000100,
        S_SQUARE = 7'b0001000,
        S_ROOT   = 7'b0010000,
        S_EMIT   = 7'b0100000,
        S_SPARE  = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_result_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_pixel_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_UPDATE;
                end
            end
            S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = i_status.produce ? S_SQUARE : S_IDLE;
            end
            S_SQUARE: begin
                o_cmd.square = 1'b1;
                n_state      = S_ROOT;
            end
            S_ROOT: begin
                o_cmd.root_step = 1'b1;
                if (i_status.root_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pixel_ready  = (r_state == S_IDLE);
    assign o_result_valid = r_out_valid;

endmodule

/* rtl/sgm_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sgm_datapath
// Line buffers, 3x3 window, row/column counters, configuration registers,
// gradient arithmetic, bit-per-cycle square root and the result register.
// ----------------------------------------------------------------------------
module sgm_datapath
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = SGM_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic [PIX_W-1:0]         i_pixel,
    input  t_dp_cmd                  i_cmd,
    output t_dp_status               o_status,
    output logic signed [GRAD_W-1:0] o_grad_horizontal,
    output logic signed [GRAD_W-1:0] o_grad_vertical,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic                     o_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);

    logic [CFG_WID_W-1:0] r_width;
    logic [CFG_HGT_W-1:0] r_height;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_clr;
    logic [PIX_W-1:0]     r_win [6];
    logic [PIX_W-1:0]     r_pixel;

    logic signed [GRAD_W-1:0] r_gh;
    logic signed [GRAD_W-1:0] r_gv;
    logic                     r_last;
    logic [SQ_W-1:0]          r_rem;
    logic [SQ_W-1:0]          r_root;
    logic [SQ_W-1:0]          r_bit;

    logic signed [GRAD_W-1:0] r_out_gh;
    logic signed [GRAD_W-1:0] r_out_gv;
    logic [MAG_W-1:0]         r_out_mag;
    logic                     r_out_last;

    logic [31:0]      width_ext;
    logic [31:0]      width_last_ext;
    logic [COL_W-1:0] width_last;
    logic [ROW_W-1:0] height_last;
    logic [CFG_HGT_W-1:0] height_m1;
    logic             col_end;
    logic             row_end;

    logic             ram_we;
    logic [COL_W-1:0] ram_addr;
    logic [PIX_W-1:0] upper_wdata;
    logic [PIX_W-1:0] middle_wdata;
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;

    logic [SUM_W-1:0] sum_left;
    logic [SUM_W-1:0] sum_right;
    logic [SUM_W-1:0] sum_top;
    logic [SUM_W-1:0] sum_bottom;
    logic signed [2*GRAD_W-1:0] sq_h;
    logic signed [2*GRAD_W-1:0] sq_v;
    logic [SQ_W-1:0]  root_trial;
    logic [MAG_W-1:0] mag_round;

    // effective last column and last row indexes after clamping
    assign width_ext      = 32'(r_width);
    assign width_last_ext = (width_ext < 32'd3)       ? 32'd2 :
                            (width_ext > MAX_WIDTH)   ? 32'(MAX_WIDTH - 1) :
                            (width_ext - 32'd1);
    assign width_last     = width_last_ext[COL_W-1:0];
    assign height_m1      = r_height - CFG_HGT_W'(1);
    assign height_last    = (r_height < CFG_HGT_W'(3)) ? ROW_W'(2) :
                            (r_height > CFG_HGT_W'(SGM_MAX_HEIGHT)) ?
                            ROW_W'(SGM_MAX_HEIGHT - 1) : height_m1[ROW_W-1:0];

    assign col_end = (r_col >= width_last);
    assign row_end = (r_row >= height_last);

    assign ram_we       = i_cmd.clear_step || i_cmd.update;
    assign ram_addr     = i_cmd.clear_step ? r_clr : r_col;
    assign upper_wdata  = i_cmd.clear_step ? '0 : mid;
    assign middle_wdata = i_cmd.clear_step ? '0 : r_pixel;

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (upper_wdata),
        .o_rdata (top)
    );

    sgm_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (middle_wdata),
        .o_rdata (mid)
    );

    // window columns: [0..2] two back, [3..5] one back, then top/mid/pixel
    assign sum_left   = SUM_W'(r_win[0]) + {1'b0, r_win[1], 1'b0} + SUM_W'(r_win[2]);
    assign sum_right  = SUM_W'(top) + {1'b0, mid, 1'b0} + SUM_W'(r_pixel);
    assign sum_top    = SUM_W'(r_win[0]) + {1'b0, r_win[3], 1'b0} + SUM_W'(top);
    assign sum_bottom = SUM_W'(r_win[2]) + {1'b0, r_win[5], 1'b0} + SUM_W'(r_pixel);

    assign sq_h = r_gh * r_gh;
    assign sq_v = r_gv * r_gv;

    assign root_trial = r_root + r_bit;
    assign mag_round  = r_root[MAG_W-1:0] + MAG_W'(r_rem > r_root);

    assign o_status.clear_done = (r_clr == COL_W'(MAX_WIDTH - 1));
    assign o_status.produce    = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_status.root_done  = r_bit[0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
            r_col    <= '0;
            r_row    <= '0;
            r_clr    <= '0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_WID_W-1:0];
                    REG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_HGT_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.clear_step) begin
                r_clr <= r_clr + COL_W'(1);
            end
            if (i_cmd.update) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_pixel;
                if (col_end) begin
                    r_col <= '0;
                    r_row <= row_end ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_col <= r_col + COL_W'(1);
                end
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pixel <= i_pixel;
        end
        if (i_cmd.update) begin
            r_gh   <= GRAD_W'({1'b0, sum_left} - {1'b0, sum_right});
            r_gv   <= GRAD_W'({1'b0, sum_top} - {1'b0, sum_bottom});
            r_last <= col_end && row_end;
        end
        if (i_cmd.square) begin
            r_rem  <= sq_h[SQ_W-1:0] + sq_v[SQ_W-1:0];
            r_root <= '0;
            r_bit  <= ROOT_BIT_INIT;
        end
        if (i_cmd.root_step) begin
            if (r_rem >= root_trial) begin
                r_rem  <= r_rem - root_trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.load_out) begin
            r_out_gh   <= r_gh;
            r_out_gv   <= r_gv;
            r_out_mag  <= mag_round;
            r_out_last <= r_last;
        end
    end

    assign o_grad_horizontal = r_out_gh;
    assign o_grad_vertical   = r_out_gv;
    assign o_magnitude       = r_out_mag;
    assign o_frame_last      = r_out_last;

endmodule

/* rtl/sobel_gradient_magnitude.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_gradient_magnitude
// 3x3 sobel edge detector on an 8-bit raster pixel stream.
//
// Pixels enter on the i_pixel valid/ready channel in raster order. For each
// pixel at row >= 2 and column >= 2 one word leaves on the result channel:
// horizontal and vertical gradients of the interior pixel one row and one
// column back, their rounded euclidean magnitude, and a flag on the last
// interior word of a frame. Border pixels give no word.
// A border pixel occupies the block through the capture and update states;
// an interior pixel also through square, the square root, which resolves
// one result bit per cycle, and emit, where the result register is loaded.
// Width and height must be written on the cfg port, by the user, only while
// the block is idle, not enforced by it; out-of-range values are clamped.
// After reset both line buffers are zeroed, one column per cycle, through all
// MAX_WIDTH columns; pixel ready stays low meanwhile (cfg writes are taken).
// A stalled receiver holds the result register; the next pixel is still
// taken and computed, and waits until the register frees.
// ----------------------------------------------------------------------------
module sobel_gradient_magnitude
    import sgm_pkg::*;
#(
    parameter int MAX_WIDTH = SGM_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                     i_pixel_valid,
    output logic                     o_pixel_ready,
    input  logic [PIX_W-1:0]         i_pixel,
    output logic                     o_result_valid,
    input  logic                     i_result_ready,
    output logic signed [GRAD_W-1:0] o_grad_horizontal,
    output logic signed [GRAD_W-1:0] o_grad_vertical,
    output logic [MAG_W-1:0]         o_magnitude,
    output logic                     o_frame_last
);

    t_dp_cmd    cmd;
    t_dp_status status;

    sgm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_valid  (i_pixel_valid),
        .o_pixel_ready  (o_pixel_ready),
        .o_result_valid (o_result_valid),
        .i_result_ready (i_result_ready),
        .o_cmd          (cmd),
        .i_status       (status)
    );

    sgm_datapath #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_pixel           (i_pixel),
        .i_cmd             (cmd),
        .o_status          (status),
        .o_grad_horizontal (o_grad_horizontal),
        .o_grad_vertical   (o_grad_vertical),
        .o_magnitude       (o_magnitude),
        .o_frame_last      (o_frame_last)
    );

endmodule
